// File: hw/rtl/afc_pkg.sv
package afc_pkg;

   localparam int REG_PLANES        = 6;
   localparam int PLANE_COUNT_DEF   = 6;
   localparam int TAG_W             = 16;
   localparam int COORD_W           = 16;
   localparam int CODE_W            = 3;
   localparam int CSR_INDEX_W       = $clog2(REG_PLANES);
   localparam int CSR_DATA_W        = 64;
   localparam int DIST_SHIFT        = 14;
   localparam int PROD_W            = 2 * COORD_W;
   localparam int SUM_W             = PROD_W + 2;

   localparam logic [CODE_W-1:0] NO_REJECT = CODE_W'(REG_PLANES);

   typedef struct packed {
      logic [TAG_W-1:0]          tag;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
   } box_type;

   typedef struct packed {
      box_type           box;
      logic [CODE_W-1:0] reject;
   } token_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

endpackage

// File: hw/rtl/afc_req_if.sv
interface afc_req_if;
   import afc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [TAG_W-1:0]          box_tag;
   logic signed [COORD_W-1:0] min_x;
   logic signed [COORD_W-1:0] min_y;
   logic signed [COORD_W-1:0] min_z;
   logic signed [COORD_W-1:0] max_x;
   logic signed [COORD_W-1:0] max_y;
   logic signed [COORD_W-1:0] max_z;

   modport source (output valid, box_tag, min_x, min_y, min_z, max_x, max_y, max_z,
                   input ready);
   modport sink (input valid, box_tag, min_x, min_y, min_z, max_x, max_y, max_z,
                 output ready);
endinterface

// File: hw/rtl/afc_rsp_if.sv
interface afc_rsp_if;
   import afc_pkg::*;

   logic              valid;
   logic              ready;
   logic [TAG_W-1:0]  tag_out;
   logic              visible;
   logic [CODE_W-1:0] reject_plane;

   modport source (output valid, tag_out, visible, reject_plane, input ready);
   modport sink (input valid, tag_out, visible, reject_plane, output ready);
endinterface

// File: hw/rtl/afc_cell.sv
module afc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  afc_pkg::csr_write_type csr,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  afc_pkg::token_type     in_tok,
   output logic                   out_valid,
   input  logic                   out_ready,
   output afc_pkg::token_type     out_tok
);
   import afc_pkg::*;

   logic [CSR_DATA_W-1:0]     plane_ff;
   logic signed [COORD_W-1:0] nx, ny, nz, plane_d;
   logic signed [COORD_W-1:0] cx, cy, cz;

   logic                      a_valid_ff;
   token_type                 a_tok_ff;
   logic signed [PROD_W-1:0]  px_ff, py_ff, pz_ff;
   logic signed [COORD_W-1:0] dist_ff;
   logic signed [PROD_W-1:0]  px_in, py_in, pz_in;
   logic                      a_ready;

   logic                      b_valid_ff;
   token_type                 b_tok_ff;
   token_type                 b_tok_in;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   thresh;
   logic                      b_ready;

   assign nx      = $signed(plane_ff[15:0]);
   assign ny      = $signed(plane_ff[31:16]);
   assign nz      = $signed(plane_ff[47:32]);
   assign plane_d = $signed(plane_ff[63:48]);

   // nearest corner: minimum where the normal is non-negative
   assign cx = nx[COORD_W-1] ? in_tok.box.max_x : in_tok.box.min_x;
   assign cy = ny[COORD_W-1] ? in_tok.box.max_y : in_tok.box.min_y;
   assign cz = nz[COORD_W-1] ? in_tok.box.max_z : in_tok.box.min_z;

   assign px_in = PROD_W'(nx) * PROD_W'(cx);
   assign py_in = PROD_W'(ny) * PROD_W'(cy);
   assign pz_in = PROD_W'(nz) * PROD_W'(cz);

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (csr.we && csr.index == CSR_INDEX_W'(CELL_INDEX)) begin
         plane_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_tok_ff <= in_tok;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         dist_ff  <= plane_d;
      end
   end

   assign sum    = SUM_W'(px_ff) + SUM_W'(py_ff) + SUM_W'(pz_ff);
   assign thresh = SUM_W'(dist_ff) <<< DIST_SHIFT;

   always_comb begin
      b_tok_in = a_tok_ff;
      if (a_tok_ff.reject == NO_REJECT && sum > thresh) begin
         b_tok_in.reject = CODE_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_tok_ff <= b_tok_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_tok   = b_tok_ff;

   a_reject_order: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_tok.reject == NO_REJECT || out_tok.reject <= CODE_W'(CELL_INDEX)))
      else $error("reject code names a later plane");

   a_plane_write: assert property (@(posedge clock) disable iff (reset)
      (csr.we && csr.index == CSR_INDEX_W'(CELL_INDEX)) |=> plane_ff == $past(csr.data))
      else $error("plane register missed a write");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !out_ready) |=> (b_valid_ff && $stable(b_tok_ff)))
      else $error("stalled item lost in cell");

endmodule

// File: hw/rtl/aabb_frustum_cull.sv
// Throughput: one item per cycle while the output is not stalled; each plane cell is a
// two-stage pipe (multiply, then sum and compare) that hands its item to the next cell
// every cycle unless stalled. A stalled output holds in the same cycle each full stage
// with no empty stage ahead of it; empty stages keep taking items.
// Reset empties the pipe and clears all plane registers to zero, which never reject.
module aabb_frustum_cull #(
   parameter int PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   afc_req_if.sink                          req_chan,
   afc_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [afc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [afc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import afc_pkg::*;

   localparam int TESTED = (PLANE_COUNT > REG_PLANES) ? REG_PLANES : PLANE_COUNT;

   csr_write_type csr;
   logic          valid [TESTED+1];
   logic          ready [TESTED+1];
   token_type     tok   [TESTED+1];

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   assign valid[0]         = req_chan.valid;
   assign req_chan.ready   = ready[0];
   assign tok[0].box.tag   = req_chan.box_tag;
   assign tok[0].box.min_x = req_chan.min_x;
   assign tok[0].box.min_y = req_chan.min_y;
   assign tok[0].box.min_z = req_chan.min_z;
   assign tok[0].box.max_x = req_chan.max_x;
   assign tok[0].box.max_y = req_chan.max_y;
   assign tok[0].box.max_z = req_chan.max_z;
   assign tok[0].reject    = NO_REJECT;

   for (genvar i = 0; i < TESTED; i++) begin : g_cell
      afc_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr       (csr),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_tok    (tok[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_tok   (tok[i+1])
      );
   end

   assign rsp_chan.valid        = valid[TESTED];
   assign ready[TESTED]         = rsp_chan.ready;
   assign rsp_chan.tag_out      = tok[TESTED].box.tag;
   assign rsp_chan.visible      = (tok[TESTED].reject == NO_REJECT);
   assign rsp_chan.reject_plane = tok[TESTED].reject;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import afc_pkg::*;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic              visible;
      logic [CODE_W-1:0] plane;
   } verdict_type;

   class cull_scoreboard;
      logic [CSR_DATA_W-1:0] planes [REG_PLANES];
      verdict_type           expected_verdicts [$];
      int                    errors;
      int                    verdicts_seen;
      int                    code_hits [REG_PLANES+1];

      function new();
         foreach (planes[i]) planes[i] = '0;
         foreach (code_hits[i]) code_hits[i] = 0;
         errors = 0;
         verdicts_seen = 0;
      endfunction

      function void load_plane(int idx, logic [CSR_DATA_W-1:0] value);
         if (idx < REG_PLANES) planes[idx] = value;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      // nearest corner per plane, first plane whose dot product exceeds d * 2^14
      function logic [CODE_W-1:0] first_rejecting_plane(box_type b);
         longint lo [3];
         longint hi [3];
         longint acc;
         longint n;
         longint plane_d;
         lo[0] = longint'($signed(b.min_x));
         lo[1] = longint'($signed(b.min_y));
         lo[2] = longint'($signed(b.min_z));
         hi[0] = longint'($signed(b.max_x));
         hi[1] = longint'($signed(b.max_y));
         hi[2] = longint'($signed(b.max_z));
         for (int p = 0; p < REG_PLANES && p < PLANE_COUNT_DEF; p++) begin
            acc = 0;
            for (int a = 0; a < 3; a++) begin
               n = longint'($signed(planes[p][16*a +: 16]));
               acc += n * ((n >= 0) ? lo[a] : hi[a]);
            end
            plane_d = longint'($signed(planes[p][63:48]));
            if (acc > plane_d * (longint'(1) << DIST_SHIFT)) return CODE_W'(p);
         end
         return NO_REJECT;
      endfunction

      function void note_box(box_type b);
         verdict_type v;
         v.tag = b.tag;
         v.plane = first_rejecting_plane(b);
         v.visible = (v.plane == NO_REJECT);
         expected_verdicts.push_back(v);
      endfunction

      task report_mismatch(input string what);
         if (errors < 50) $display("tb_top: mismatch: %s", what);
         errors++;
      endtask

      task check_verdict(input logic [TAG_W-1:0] tag, input logic vis,
                         input logic [CODE_W-1:0] code);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("result tag %h with no box pending", tag));
            return;
         end
         want = expected_verdicts.pop_front();
         verdicts_seen++;
         code_hits[want.plane]++;
         if (tag !== want.tag)
            report_mismatch($sformatf("tag: got %h, expected %h", tag, want.tag));
         if (vis !== want.visible)
            report_mismatch($sformatf("visible for tag %h: got %b, expected %b",
                                      want.tag, vis, want.visible));
         if (code !== want.plane)
            report_mismatch($sformatf("reject_plane for tag %h: got %0d, expected %0d",
                                      want.tag, code, want.plane));
      endtask
   endclass

   localparam int RANDOM_PHASES    = 12;
   localparam int BOXES_PER_PHASE  = 125;
   localparam int HOLD_PHASE       = 4;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 40;

   localparam logic [15:0] NORMAL_POS = 16'h4000;
   localparam logic [15:0] NORMAL_NEG = 16'hC000;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [CSR_DATA_W-1:0] plane_plan [REG_PLANES];
   bit idle_on;
   bit long_hold_request;
   int quiet_cycles;
   int settings_loaded;

   cull_scoreboard sb;

   afc_req_if req_bus ();
   afc_rsp_if rsp_bus ();

   aabb_frustum_cull DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_verdict(rsp_bus.tag_out, rsp_bus.visible, rsp_bus.reject_plane);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: watchdog, no handshake for %0d cycles", quiet_cycles);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic box_type make_box(logic [TAG_W-1:0] tag, int mnx, int mny, int mnz,
                                        int mxx, int mxy, int mxz);
      box_type b;
      b.tag = tag;
      b.min_x = 16'(mnx);
      b.min_y = 16'(mny);
      b.min_z = 16'(mnz);
      b.max_x = 16'(mxx);
      b.max_y = 16'(mxy);
      b.max_z = 16'(mxz);
      return b;
   endfunction

   function automatic box_type random_box(int spread);
      int edges [5] = '{-32768, 32767, 0, -1, 1};
      int lo [3];
      int hi [3];
      int c;
      int h;
      int pick;
      pick = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         if (pick < 7) begin
            c = int'($urandom_range(0, 2 * spread)) - spread;
            h = $urandom_range(0, spread / 2);
            lo[a] = c - h;
            hi[a] = c + h;
         end else if (pick < 9) begin
            lo[a] = int'($signed(16'($urandom)));
            hi[a] = int'($signed(16'($urandom)));
         end else begin
            lo[a] = edges[$urandom_range(0, 4)];
            hi[a] = edges[$urandom_range(0, 4)];
         end
      end
      return make_box(16'($urandom), lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   // axis-aligned plane: positive normal rejects min > d, negative rejects max < -d
   function automatic logic [CSR_DATA_W-1:0] cage_plane(int axis, bit negative, int plane_d);
      logic [CSR_DATA_W-1:0] v;
      v = '0;
      v[16*axis +: 16] = negative ? NORMAL_NEG : NORMAL_POS;
      v[63:48] = 16'(plane_d);
      return v;
   endfunction

   task automatic offer_box(input box_type b);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.box_tag <= b.tag;
      req_bus.min_x   <= b.min_x;
      req_bus.min_y   <= b.min_y;
      req_bus.min_z   <= b.min_z;
      req_bus.max_x   <= b.max_x;
      req_bus.max_y   <= b.max_y;
      req_bus.max_z   <= b.max_z;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_box(b);
   endtask

   task automatic write_reg(input int idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_INDEX_W'(idx);
      csr_wdata <= value;
      sb.load_plane(idx, value);
   endtask

   // drain the pipe, then load all planes and hit the unused indexes too
   task automatic apply_planes(input logic [CSR_DATA_W-1:0] spare);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
      for (int i = 0; i < REG_PLANES; i++) write_reg(i, plane_plan[i]);
      for (int i = REG_PLANES; i < 2 ** CSR_INDEX_W; i++) write_reg(i, spare);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   initial begin
      int spread;
      logic [15:0] n [3];
      logic [15:0] d;
      int lo;
      int hi;

      sb = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.box_tag = '0;
      req_bus.min_x = '0;
      req_bus.min_y = '0;
      req_bus.min_z = '0;
      req_bus.max_x = '0;
      req_bus.max_y = '0;
      req_bus.max_z = '0;
      idle_on = 1'b1;
      long_hold_request = 1'b0;
      quiet_cycles = 0;
      settings_loaded = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // planes at reset value never reject, whatever the box
      offer_box(make_box(16'h0000, -32768, -32768, -32768, 32767, 32767, 32767));
      offer_box(make_box(16'hFFFF, 32767, 32767, 32767, -32768, -32768, -32768));
      offer_box(make_box(16'hA5A5, 0, 0, 0, 0, 0, 0));
      offer_box(make_box(16'h5A5A, 10, -20, 30, -10, 20, -30));

      // cube cage of half-size 100
      for (int a = 0; a < 3; a++) begin
         plane_plan[2*a]   = cage_plane(a, 1'b0, 100);
         plane_plan[2*a+1] = cage_plane(a, 1'b1, 100);
      end
      apply_planes({2{32'hFFFF_FFFF}});
      offer_box(make_box(16'h0100, -10, -10, -10, 10, 10, 10));
      offer_box(make_box(16'h0101, 101, 0, 0, 200, 0, 0));
      offer_box(make_box(16'h0102, 100, 0, 0, 200, 0, 0));
      offer_box(make_box(16'h0103, -200, 0, 0, -101, 0, 0));
      offer_box(make_box(16'h0104, 0, 150, 0, 0, 160, 0));
      offer_box(make_box(16'h0105, 0, -400, 0, 0, -300, 0));
      offer_box(make_box(16'h0106, 0, 0, 101, 0, 0, 101));
      offer_box(make_box(16'h0107, 0, 0, -102, 0, 0, -101));
      offer_box(make_box(16'h0108, 50, 0, 0, -50, 0, 0));
      offer_box(make_box(16'h0109, 0, 90, 0, 0, -150, 0));

      // largest positive normals and distance
      foreach (plane_plan[i]) plane_plan[i] = {4{16'h7FFF}};
      apply_planes({2{32'h5555_AAAA}});
      offer_box(make_box(16'h0200, 32767, 32767, 32767, 32767, 32767, 32767));
      offer_box(make_box(16'h0201, -32768, -32768, -32768, 32767, 32767, 32767));
      offer_box(make_box(16'h0202, 5462, 5462, 5462, 6000, 6000, 6000));

      // most negative normals and distance; unused indexes written with zero
      foreach (plane_plan[i]) plane_plan[i] = {4{16'h8000}};
      apply_planes('0);
      offer_box(make_box(16'h0300, -32768, -32768, -32768, 32767, 32767, 32767));
      offer_box(make_box(16'h0301, -32768, -32768, -32768, -32768, -32768, -32768));
      offer_box(make_box(16'h0302, -100, -100, -100, 5461, 5461, 5461));

      foreach (plane_plan[i]) plane_plan[i] = {CSR_DATA_W{1'b1}};
      apply_planes({2{32'h8000_0001}});
      offer_box(make_box(16'h0400, 0, 0, 0, 32767, 32767, 32767));
      offer_box(make_box(16'h0401, 0, 0, 0, 0, 0, 0));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 3)
            0: begin
               for (int a = 0; a < 3; a++) begin
                  lo = -int'($urandom_range(500, 6000));
                  hi = $urandom_range(500, 6000);
                  plane_plan[2*a]   = cage_plane(a, 1'b0, hi);
                  plane_plan[2*a+1] = cage_plane(a, 1'b1, -lo);
               end
               spread = 8000;
            end
            1: begin
               foreach (plane_plan[i]) begin
                  for (int a = 0; a < 3; a++) n[a] = 16'(int'($urandom_range(0, 32768)) - 16384);
                  d = 16'(int'($urandom_range(0, 8000)) - 4000);
                  plane_plan[i] = ($urandom_range(0, 2) == 0) ? '0 : {d, n[2], n[1], n[0]};
               end
               spread = 6000;
            end
            default: begin
               foreach (plane_plan[i]) plane_plan[i] = {$urandom, $urandom};
               spread = 16000;
            end
         endcase
         apply_planes({$urandom, $urandom});
         if (ph == HOLD_PHASE) long_hold_request = 1'b1;
         if (ph >= RANDOM_PHASES - 2) idle_on = 1'b0;
         repeat (BOXES_PER_PHASE) offer_box(random_box(spread));
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d boxes checked under %0d plane settings, %0d visible",
               sb.verdicts_seen, settings_loaded, sb.code_hits[NO_REJECT]);
      $display("tb_top: rejects by first plane 0..5: %0d %0d %0d %0d %0d %0d",
               sb.code_hits[0], sb.code_hits[1], sb.code_hits[2],
               sb.code_hits[3], sb.code_hits[4], sb.code_hits[5]);
      if (sb.errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
